// File: src/idq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_pkg: shared types for the indexed deque
// Request and status codes, the per-cell operation and the result flags
// handed from the controller to the top level.
// ----------------------------------------------------------------------------
package idq_pkg;

    localparam int REQ_W = 3;
    localparam int POS_W = 5;
    localparam int ITEM_W = 32;
    localparam int COUNT_OUT_W = 5;

    localparam logic [REQ_W-1:0] REQ_PUT_FRONT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUT_BACK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TAKE_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_TAKE_BACK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd5;
    localparam logic [REQ_W-1:0] REQ_REPLACE    = 3'd6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_OPEN  = 2'd1,
        CELL_CLOSE = 2'd2,
        CELL_WRITE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_status status;
        logic    has_value;
    } t_ctrl_res;

endpackage

// File: src/idq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_cell: one storage cell of the deque chain
// Holds one entry and, on each cycle, keeps it, takes the word of either
// neighbour or loads the new word, according to the broadcast operation.
// ----------------------------------------------------------------------------
module idq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  idq_pkg::t_cell_op     i_op,
    input  logic [IDX_W-1:0]      i_pos,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [IDX_W-1:0] HERE = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_op)
            idq_pkg::CELL_HOLD: begin
                n_data = r_data;
            end
            idq_pkg::CELL_OPEN: begin
                if (HERE == i_pos) begin
                    n_data = i_value;
                end else if (HERE > i_pos) begin
                    n_data = i_left;
                end
            end
            idq_pkg::CELL_CLOSE: begin
                if (HERE >= i_pos) begin
                    n_data = i_right;
                end
            end
            idq_pkg::CELL_WRITE: begin
                if (HERE == i_pos) begin
                    n_data = i_value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: src/idq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_ctrl: request decoder and entry counter
// Checks each request against the entry count, raises the cell operation
// for the chain, picks the entry to read and keeps the count.
// ----------------------------------------------------------------------------
module idq_ctrl #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [idq_pkg::REQ_W-1:0]     i_req_type,
    input  logic [idq_pkg::POS_W-1:0]     i_position,
    output idq_pkg::t_cell_op             o_op,
    output logic [IDX_W-1:0]              o_pos,
    output logic [IDX_W-1:0]              o_sel,
    output idq_pkg::t_ctrl_res            o_res,
    output logic [CNT_W-1:0]              o_count_next
);

    localparam int EXT_W = (CNT_W > idq_pkg::POS_W) ? CNT_W : idq_pkg::POS_W;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [EXT_W-1:0] pos_ext;
    logic [EXT_W-1:0] cnt_ext;
    logic             full;
    logic             empty;
    idq_pkg::t_cell_op op;

    assign pos_ext = EXT_W'(i_position);
    assign cnt_ext = EXT_W'(r_count);
    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);

    always_comb begin
        op              = idq_pkg::CELL_HOLD;
        o_pos           = '0;
        o_sel           = '0;
        o_res.status    = idq_pkg::ST_OK;
        o_res.has_value = 1'b0;
        n_count         = r_count;
        unique case (i_req_type)
            idq_pkg::REQ_PUT_FRONT: begin
                if (full) begin
                    o_res.status = idq_pkg::ST_OVER;
                end else begin
                    op      = idq_pkg::CELL_OPEN;
                    n_count = r_count + CNT_W'(1);
                end
            end
            idq_pkg::REQ_PUT_BACK: begin
                if (full) begin
                    o_res.status = idq_pkg::ST_OVER;
                end else begin
                    op      = idq_pkg::CELL_OPEN;
                    o_pos   = IDX_W'(r_count);
                    n_count = r_count + CNT_W'(1);
                end
            end
            idq_pkg::REQ_TAKE_FRONT: begin
                if (empty) begin
                    o_res.status = idq_pkg::ST_UNDER;
                end else begin
                    op              = idq_pkg::CELL_CLOSE;
                    o_res.has_value = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            idq_pkg::REQ_TAKE_BACK: begin
                if (empty) begin
                    o_res.status = idq_pkg::ST_UNDER;
                end else begin
                    op              = idq_pkg::CELL_CLOSE;
                    o_pos           = IDX_W'(r_count - CNT_W'(1));
                    o_sel           = IDX_W'(r_count - CNT_W'(1));
                    o_res.has_value = 1'b1;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            idq_pkg::REQ_READ: begin
                if (pos_ext >= cnt_ext) begin
                    o_res.status = idq_pkg::ST_RANGE;
                end else begin
                    o_sel           = IDX_W'(pos_ext);
                    o_res.has_value = 1'b1;
                end
            end
            idq_pkg::REQ_INSERT: begin
                if (full) begin
                    o_res.status = idq_pkg::ST_OVER;
                end else if (pos_ext > cnt_ext) begin
                    o_res.status = idq_pkg::ST_RANGE;
                end else begin
                    op      = idq_pkg::CELL_OPEN;
                    o_pos   = IDX_W'(pos_ext);
                    n_count = r_count + CNT_W'(1);
                end
            end
            idq_pkg::REQ_REPLACE: begin
                if (pos_ext >= cnt_ext) begin
                    o_res.status = idq_pkg::ST_RANGE;
                end else begin
                    op    = idq_pkg::CELL_WRITE;
                    o_pos = IDX_W'(pos_ext);
                end
            end
            default: begin
                op = idq_pkg::CELL_HOLD;
            end
        endcase
    end

    assign o_op         = i_accept ? op : idq_pkg::CELL_HOLD;
    assign o_count_next = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

endmodule

// File: src/indexed_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque: bounded deque of signed words with indexed access
// Usage: each input item is one request (push front or back, pop front or
// back, read, insert or replace at a position). The deque answers every
// request with exactly one output item carrying the word taken out or read,
// a status, the entry count after the request and an empty flag.
// Both channels use valid and stall; an item moves at a clock edge where
// valid is high and stall is low.
// The result is registered: the result of a request accepted at one edge is
// presented at the output from that edge on. The deque takes one request per
// cycle while the output is not stalled, as the chain of cells shifts, loads
// or holds in parallel in the same cycle.
// While the receiver stalls, the pending result is held and the input is
// stalled, so the next request waits until the result has been taken.
// A synchronous reset empties the deque and drops any pending result; the
// cell contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
module indexed_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic        [idq_pkg::REQ_W-1:0]       i_req_type,
    input  logic        [idq_pkg::POS_W-1:0]       i_position,
    input  logic signed [idq_pkg::ITEM_W-1:0]      i_item_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [idq_pkg::ITEM_W-1:0]      o_out_value,
    output logic        [1:0]                      o_status,
    output logic        [idq_pkg::COUNT_OUT_W-1:0] o_count_after,
    output logic                                   o_is_empty
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                      accept;
    idq_pkg::t_cell_op         cell_op;
    logic [IDX_W-1:0]          cell_pos;
    logic [IDX_W-1:0]          rd_sel;
    idq_pkg::t_ctrl_res        ctrl_res;
    logic [CNT_W-1:0]          count_next;
    logic [63:0]               value_wide;
    logic [DATA_WIDTH-1:0]     store_value;
    logic [DATA_WIDTH-1:0]     cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]     rd_data;
    logic signed [63:0]        rd_wide;

    logic                              r_out_valid;
    logic [idq_pkg::ITEM_W-1:0]        r_out_value;
    idq_pkg::t_status                  r_status;
    logic [idq_pkg::COUNT_OUT_W-1:0]   r_count_after;
    logic                              r_is_empty;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign value_wide  = 64'($unsigned(i_item_value));
    assign store_value = value_wide[DATA_WIDTH-1:0];

    idq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_position   (i_position),
        .o_op         (cell_op),
        .o_pos        (cell_pos),
        .o_sel        (rd_sel),
        .o_res        (ctrl_res),
        .o_count_next (count_next)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = store_value;
        end else begin : g_inner_left
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_inner_right
            assign right_data = cell_data[g+1];
        end

        idq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_pos   (cell_pos),
            .i_value (store_value),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[g])
        );
    end

    assign rd_data = cell_data[rd_sel];
    assign rd_wide = 64'(signed'(rd_data));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value   <= ctrl_res.has_value ? rd_wide[idq_pkg::ITEM_W-1:0] : '0;
            r_status      <= ctrl_res.status;
            r_count_after <= idq_pkg::COUNT_OUT_W'(count_next);
            r_is_empty    <= (count_next == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = signed'(r_out_value);
    assign o_status      = r_status;
    assign o_count_after = r_count_after;
    assign o_is_empty    = r_is_empty;

endmodule
